### design/mnslr_pkg.sv
// Shared types, codes and helpers for the MIDI note split/layer router.
// Used by midi_note_split_layer_router; has no dependencies of its own.
`default_nettype none

package mnslr_pkg;

   localparam int MNSLR_ZONES  = 16;
   localparam int KEYS         = 128;
   localparam int PITCH_W      = 7;
   localparam int CHAN_W       = 4;
   localparam int ZIDX_W       = 4;
   localparam int KIND_W       = 2;
   localparam int REQ_DATA_W   = 72;
   localparam int REQ_USER_W   = 4;
   localparam int RSP_DATA_W   = 24;
   localparam int RSP_USER_W   = 3;

   typedef enum logic [1:0] {
      CMD_EVENT       = 2'd0,
      CMD_WRITE_ZONE  = 2'd1,
      CMD_LEARN_START = 2'd2,
      CMD_LEARN_END   = 2'd3
   } cmd_type;

   localparam logic [KIND_W-1:0] KIND_NOTE_ON  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_NOTE_OFF = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_LEARN,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic signed [7:0] velo_shift;
      logic signed [7:0] transpose;
      logic [7:0]        velo_high;
      logic [7:0]        velo_low;
      logic [7:0]        pitch_high;
      logic [7:0]        pitch_low;
   } zone_type;

   // Zone 0 after reset covers every pitch and velocity with no offsets.
   localparam zone_type ZONE0_RESET = '{
      velo_shift: 8'sd0, transpose: 8'sd0,
      velo_high: 8'd128, velo_low: 8'd0,
      pitch_high: 8'd128, pitch_low: 8'd0};

   typedef struct packed {
      logic                learned;
      logic [KIND_W-1:0]   kind;
      logic [CHAN_W-1:0]   chan;
      logic [PITCH_W-1:0]  first;
      logic [PITCH_W-1:0]  second;
   } res_type;

   function automatic logic [PITCH_W-1:0] clamp7(input logic signed [8:0] v);
      logic [PITCH_W-1:0] r;
      if (v < 9'sd0) begin
         r = '0;
      end else if (v > 9'sd127) begin
         r = 7'd127;
      end else begin
         r = v[PITCH_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### design/mnslr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Standalone; used for the zone table and the held-note masks.
`default_nettype none

module mnslr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/midi_note_split_layer_router.sv
// MIDI note split/layer router: zone table, held-note masks and learn logic.
// Depends on mnslr_pkg and mnslr_ram.
//
// Requests arrive on the req_ stream: tuser carries the command and the event
// kind, tdata the event bytes and the zone fields. Commands that write a zone
// or arm learning give no result. A pass-through event and a learn capture
// each give one result. A note is routed by scanning the zone table one zone
// per cycle from its memory while the receiver keeps up; the block takes the
// next request only once the scan is over and its last result is registered.
// The scan length is set by the single read port of the zone memory.
// Results leave on the rsp_ stream; rsp_tlast marks the last result caused by
// a request. One result is held back until the next one is found, so tlast is
// known when it is presented. When the receiver stalls, the scan stops on the
// next zone that has a result and waits; nothing is lost or repeated.
// After reset a clearing pass over the 128 keys zeroes the held-note masks and
// loads the reset zone table; req_tready stays low during that pass.
`default_nettype none

module midi_note_split_layer_router
   import mnslr_pkg::*;
#(
   parameter int ZONES = MNSLR_ZONES
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [3:0] event_channel, [10:4] first_data, [17:11] second_data,
   // [21:18] zone_index, [29:22] zone_pitch_low, [37:30] zone_pitch_high,
   // [45:38] zone_velo_low, [53:46] zone_velo_high, [61:54] zone_transpose,
   // [69:62] zone_velo_shift, [71:70] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] command, [3:2] event_kind
   input  wire logic [REQ_USER_W-1:0] req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [3:0] out_channel, [10:4] out_first, [17:11] out_second, [23:18] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // [1:0] out_kind, [2] learned
   output logic [RSP_USER_W-1:0]      rsp_tuser,
   output logic                       rsp_tlast
);

   localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam logic [ZW-1:0]      ZLAST    = ZW'(ZONES - 1);
   localparam logic [ZIDX_W:0]    ZONE_LIM = (ZIDX_W + 1)'(ZONES);
   localparam logic [PITCH_W-1:0] ZONES_K  = PITCH_W'(ZONES);
   localparam logic [PITCH_W-1:0] KEY_LAST = PITCH_W'(KEYS - 1);

   // Request fields.
   cmd_type             in_cmd;
   logic [KIND_W-1:0]   in_kind;
   logic [CHAN_W-1:0]   in_chan;
   logic [PITCH_W-1:0]  in_first;
   logic [PITCH_W-1:0]  in_second;
   logic [ZIDX_W-1:0]   in_zone;
   zone_type            in_zone_entry;
   logic                in_zone_ok;

   assign in_cmd    = cmd_type'(req_tuser[1:0]);
   assign in_kind   = req_tuser[3:2];
   assign in_chan   = req_tdata[3:0];
   assign in_first  = req_tdata[10:4];
   assign in_second = req_tdata[17:11];
   assign in_zone   = req_tdata[21:18];
   assign in_zone_entry.pitch_low  = req_tdata[29:22];
   assign in_zone_entry.pitch_high = req_tdata[37:30];
   assign in_zone_entry.velo_low   = req_tdata[45:38];
   assign in_zone_entry.velo_high  = req_tdata[53:46];
   assign in_zone_entry.transpose  = req_tdata[61:54];
   assign in_zone_entry.velo_shift = req_tdata[69:62];
   assign in_zone_ok = ({1'b0, in_zone} < ZONE_LIM);

   // Control state.
   state_type           state_ff, state_in;
   logic [PITCH_W-1:0]  clr_ff, clr_in;
   logic                learn_armed_ff, learn_armed_in;
   logic [ZW-1:0]       learn_zone_ff, learn_zone_in;
   logic                learn_start_ff, learn_start_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Payload of the note being worked on.
   logic [ZW-1:0]       z_ff, z_in;
   logic [ZONES-1:0]    hits_ff, hits_in;
   logic                note_on_ff, note_on_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [PITCH_W-1:0]  pitch_ff, pitch_in;
   logic [PITCH_W-1:0]  velo_ff, velo_in;
   res_type             pend_ff, pend_in;
   res_type             rsp_ff, rsp_in;
   logic                rsp_last_ff, rsp_last_in;

   // Memory ports.
   logic                zram_we, zram_re;
   logic [ZW-1:0]       zram_waddr, zram_raddr;
   zone_type            zram_wdata, zone_rd;
   logic                mram_we, mram_re;
   logic [PITCH_W-1:0]  mram_waddr, mram_raddr;
   logic [ZONES-1:0]    mram_wdata, mask_rd;

   mnslr_ram #(.WIDTH($bits(zone_type)), .DEPTH(ZONES)) u_zone_ram (
      .clock   (clock),
      .wr_en   (zram_we),
      .wr_addr (zram_waddr),
      .wr_data (zram_wdata),
      .rd_en   (zram_re),
      .rd_addr (zram_raddr),
      .rd_data (zone_rd)
   );

   mnslr_ram #(.WIDTH(ZONES), .DEPTH(KEYS)) u_mask_ram (
      .clock   (clock),
      .wr_en   (mram_we),
      .wr_addr (mram_waddr),
      .wr_data (mram_wdata),
      .rd_en   (mram_re),
      .rd_addr (mram_raddr),
      .rd_data (mask_rd)
   );

   // Evaluation of the zone whose entry is on the read port.
   logic                zone_hit, sel_hit, slot_free;
   logic signed [8:0]   sum_pitch, sum_velo;
   res_type             scan_res, learn_res, pass_res;
   zone_type            learn_entry;
   logic [ZONES-1:0]    hits_nx;

   assign zone_hit = ({1'b0, pitch_ff} >= zone_rd.pitch_low) &&
                     ({1'b0, pitch_ff} <= zone_rd.pitch_high) &&
                     ({1'b0, velo_ff} >= zone_rd.velo_low) &&
                     ({1'b0, velo_ff} <= zone_rd.velo_high);
   assign sel_hit   = note_on_ff ? zone_hit : mask_rd[z_ff];
   assign sum_pitch = $signed({2'b00, pitch_ff}) +
                      $signed({zone_rd.transpose[7], zone_rd.transpose});
   assign sum_velo  = $signed({2'b00, velo_ff}) +
                      $signed({zone_rd.velo_shift[7], zone_rd.velo_shift});
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      scan_res.learned = 1'b0;
      scan_res.kind    = kind_ff;
      scan_res.chan    = CHAN_W'(z_ff);
      scan_res.first   = clamp7(sum_pitch);
      scan_res.second  = note_on_ff ? clamp7(sum_velo) : velo_ff;

      learn_res.learned = 1'b1;
      learn_res.kind    = KIND_NOTE_ON;
      learn_res.chan    = CHAN_W'(learn_zone_ff);
      learn_res.first   = pitch_ff;
      learn_res.second  = '0;

      pass_res.learned = 1'b0;
      pass_res.kind    = KIND_OTHER;
      pass_res.chan    = in_chan;
      pass_res.first   = in_first;
      pass_res.second  = in_second;

      learn_entry = zone_rd;
      if (learn_start_ff) begin
         learn_entry.pitch_low = {1'b0, pitch_ff};
      end else begin
         learn_entry.pitch_high = {1'b0, pitch_ff};
      end

      hits_nx = hits_ff;
      hits_nx[z_ff] = hits_ff[z_ff] | sel_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         learn_armed_ff <= 1'b0;
         learn_zone_ff  <= '0;
         learn_start_ff <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_ff         <= clr_in;
         learn_armed_ff <= learn_armed_in;
         learn_zone_ff  <= learn_zone_in;
         learn_start_ff <= learn_start_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      hits_ff     <= hits_in;
      note_on_ff  <= note_on_in;
      kind_ff     <= kind_in;
      pitch_ff    <= pitch_in;
      velo_ff     <= velo_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      logic    out_load;
      res_type out_data;
      logic    out_last;

      state_in       = state_ff;
      clr_in         = clr_ff;
      learn_armed_in = learn_armed_ff;
      learn_zone_in  = learn_zone_ff;
      learn_start_in = learn_start_ff;
      pend_valid_in  = pend_valid_ff;
      z_in           = z_ff;
      hits_in        = hits_ff;
      note_on_in     = note_on_ff;
      kind_in        = kind_ff;
      pitch_in       = pitch_ff;
      velo_in        = velo_ff;
      pend_in        = pend_ff;

      out_load = 1'b0;
      out_data = pend_ff;
      out_last = 1'b0;

      zram_we    = 1'b0;
      zram_waddr = learn_zone_ff;
      zram_wdata = learn_entry;
      zram_re    = 1'b0;
      zram_raddr = ZW'(z_ff + 1'b1);
      mram_we    = 1'b0;
      mram_waddr = pitch_ff;
      mram_wdata = '0;
      mram_re    = 1'b0;
      mram_raddr = in_first;

      req_tready = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mram_we    = 1'b1;
            mram_waddr = clr_ff;
            if (clr_ff < ZONES_K) begin
               zram_we    = 1'b1;
               zram_waddr = clr_ff[ZW-1:0];
               zram_wdata = (clr_ff == '0) ? ZONE0_RESET : '0;
            end
            if (clr_ff == KEY_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            zram_raddr = learn_armed_ff ? learn_zone_ff : '0;
            if (req_tvalid) begin
               case (in_cmd)
                  CMD_WRITE_ZONE: begin
                     if (in_zone_ok) begin
                        zram_we    = 1'b1;
                        zram_waddr = in_zone[ZW-1:0];
                        zram_wdata = in_zone_entry;
                     end
                  end
                  CMD_LEARN_START, CMD_LEARN_END: begin
                     if (in_zone_ok) begin
                        learn_armed_in = 1'b1;
                        learn_zone_in  = in_zone[ZW-1:0];
                        learn_start_in = (in_cmd == CMD_LEARN_START);
                     end
                  end
                  CMD_EVENT: begin
                     pitch_in   = in_first;
                     velo_in    = in_second;
                     kind_in    = in_kind;
                     note_on_in = (in_kind == KIND_NOTE_ON) && (in_second != '0);
                     z_in       = '0;
                     hits_in    = '0;
                     if (in_kind[1]) begin
                        // Kinds two and three pass through as kind other, bytes unchanged.
                        pend_in       = pass_res;
                        pend_valid_in = 1'b1;
                        state_in      = ST_FLUSH;
                     end else if (learn_armed_ff) begin
                        zram_re  = 1'b1;
                        state_in = ST_LEARN;
                     end else begin
                        zram_re  = 1'b1;
                        mram_re  = 1'b1;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (!(sel_hit && pend_valid_ff && !slot_free)) begin
               if (sel_hit) begin
                  out_load      = pend_valid_ff;
                  out_data      = pend_ff;
                  pend_in       = scan_res;
                  pend_valid_in = 1'b1;
               end
               hits_in = hits_nx;
               if (z_ff == ZLAST) begin
                  mram_we    = 1'b1;
                  mram_wdata = note_on_ff ? (mask_rd | hits_nx) : '0;
                  state_in   = ST_FLUSH;
               end else begin
                  zram_re = 1'b1;
                  z_in    = ZW'(z_ff + 1'b1);
               end
            end
         end

         ST_LEARN: begin
            zram_we        = 1'b1;
            learn_armed_in = 1'b0;
            pend_in        = learn_res;
            pend_valid_in  = 1'b1;
            state_in       = ST_FLUSH;
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               out_load      = 1'b1;
               out_data      = pend_ff;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in      = out_load ? out_data : rsp_ff;
      rsp_last_in = out_load ? out_last : rsp_last_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_ff.second, rsp_ff.first, rsp_ff.chan};
   assign rsp_tuser  = {rsp_ff.learned, rsp_ff.kind};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### sim/tb_midi_note_split_layer_router.sv
// Self-checking bench for the MIDI note split/layer router: directed and random
// requests are routed through a behavioral zone model held in the bench.
// Depends on mnslr_pkg and midi_note_split_layer_router, which needs mnslr_ram.
`timescale 1ns / 100ps

module tb_midi_note_split_layer_router;
   import mnslr_pkg::*;

   // The slowest correct run has about 200 requests, each fanning out to 16
   // results that each wait out the longest stall, plus the clearing pass after
   // reset. The limit is a few times that figure.
   localparam int CYCLE_LIMIT  = 600000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_REQS  = 146;
   localparam int PITCH_MAX    = 127;

   // Event kind 3 has no meaning of its own and is passed on as an other event.
   localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

   // Indexes into the table of quiet stretches, one for each side of the block.
   localparam int SIDE_REQ = 0;
   localparam int SIDE_RSP = 1;

   typedef struct {
      cmd_type               cmd;
      logic [KIND_W-1:0]     kind;
      logic [CHAN_W-1:0]     chan;
      logic [PITCH_W-1:0]    first;
      logic [PITCH_W-1:0]    second;
      logic [ZIDX_W-1:0]     zone;
      logic [7:0]            pitch_low;
      logic [7:0]            pitch_high;
      logic [7:0]            velo_low;
      logic [7:0]            velo_high;
      logic signed [7:0]     transpose;
      logic signed [7:0]     velo_shift;
   } midi_req_t;

   typedef struct {
      logic [KIND_W-1:0]     kind;
      logic [CHAN_W-1:0]     chan;
      logic [PITCH_W-1:0]    first;
      logic [PITCH_W-1:0]    second;
      logic                  learned;
      logic                  last;
   } note_out_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [REQ_USER_W-1:0]   req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [RSP_USER_W-1:0]   rsp_tuser;
   logic                    rsp_tlast;

   // The bench's own copy of the zone table, the held-note masks and the
   // learn state. It is updated when a request is accepted.
   logic [7:0]              zn_pitch_low  [MNSLR_ZONES];
   logic [7:0]              zn_pitch_high [MNSLR_ZONES];
   logic [7:0]              zn_velo_low   [MNSLR_ZONES];
   logic [7:0]              zn_velo_high  [MNSLR_ZONES];
   logic signed [7:0]       zn_transpose  [MNSLR_ZONES];
   logic signed [7:0]       zn_velo_shift [MNSLR_ZONES];
   logic [MNSLR_ZONES-1:0]  held_zones    [KEYS];
   logic                    learn_armed;
   logic [ZIDX_W-1:0]       learn_zone;
   logic                    learn_sets_start;

   note_out_t               expected_notes[$];
   midi_req_t               pending_reqs[$];
   midi_req_t               req_item;

   int                      req_queued = 0;
   int                      req_accepted = 0;
   int                      mismatches = 0;
   int                      cycle_count = 0;
   int                      req_wait = 0;
   int                      rsp_wait = 0;
   int                      calm_left[2] = '{0, 0};
   logic                    req_hs = 1'b0;
   logic                    rsp_hs = 1'b0;

   midi_note_split_layer_router uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Every mismatch goes through here: one line, one count.
   task automatic flag_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input int got, input int want);
      if (got != want) begin
         flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   // Pitch and velocity sums saturate at the ends of the 7-bit MIDI range.
   function automatic logic [PITCH_W-1:0] limit7(input int v);
      if (v < 0) begin
         return '0;
      end
      if (v > PITCH_MAX) begin
         return 7'(PITCH_MAX);
      end
      return v[PITCH_W-1:0];
   endfunction

   // Works out the results of one accepted request and files them in order.
   // Routed note-ons scan the zones in rising order and mark each hit in the
   // held mask of the pitch; releases replay that mask and then clear it.
   function automatic void route_request(input midi_req_t r);
      note_out_t batch[$];
      note_out_t o;
      logic [7:0] key8;
      key8 = {1'b0, r.first};
      case (r.cmd)
         CMD_WRITE_ZONE: begin
            zn_pitch_low[r.zone]  = r.pitch_low;
            zn_pitch_high[r.zone] = r.pitch_high;
            zn_velo_low[r.zone]   = r.velo_low;
            zn_velo_high[r.zone]  = r.velo_high;
            zn_transpose[r.zone]  = r.transpose;
            zn_velo_shift[r.zone] = r.velo_shift;
         end
         CMD_LEARN_START, CMD_LEARN_END: begin
            // Arming again simply replaces the zone and the target.
            learn_armed      = 1'b1;
            learn_zone       = r.zone;
            learn_sets_start = (r.cmd == CMD_LEARN_START);
         end
         default: begin
            if (r.kind == KIND_OTHER || r.kind == KIND_UNKNOWN) begin
               batch.push_back('{KIND_OTHER, r.chan, r.first, r.second, 1'b0, 1'b0});
            end else if (learn_armed) begin
               // A learn capture eats the note and leaves the held masks alone.
               if (learn_sets_start) begin
                  zn_pitch_low[learn_zone] = key8;
               end else begin
                  zn_pitch_high[learn_zone] = key8;
               end
               learn_armed = 1'b0;
               batch.push_back('{KIND_NOTE_ON, learn_zone, r.first, '0, 1'b1, 1'b0});
            end else if (r.kind == KIND_NOTE_ON && r.second != '0) begin
               for (int z = 0; z < MNSLR_ZONES; z++) begin
                  if (key8 >= zn_pitch_low[z] && key8 <= zn_pitch_high[z] &&
                      {1'b0, r.second} >= zn_velo_low[z] &&
                      {1'b0, r.second} <= zn_velo_high[z]) begin
                     held_zones[r.first][z] = 1'b1;
                     batch.push_back('{KIND_NOTE_ON, CHAN_W'(z),
                        limit7(int'(r.first) + int'(zn_transpose[z])),
                        limit7(int'(r.second) + int'(zn_velo_shift[z])), 1'b0, 1'b0});
                  end
               end
            end else begin
               // Note-off, or note-on with velocity zero: the kind is kept.
               for (int z = 0; z < MNSLR_ZONES; z++) begin
                  if (held_zones[r.first][z]) begin
                     batch.push_back('{r.kind, CHAN_W'(z),
                        limit7(int'(r.first) + int'(zn_transpose[z])),
                        r.second, 1'b0, 1'b0});
                  end
               end
               held_zones[r.first] = '0;
            end
         end
      endcase
      foreach (batch[i]) begin
         o = batch[i];
         o.last = (i == batch.size() - 1);
         expected_notes.push_back(o);
      end
   endfunction

   // Mostly no gap or a short one, now and then a long one, and from time to
   // time a quiet stretch in which that side does not idle at all.
   function automatic int pick_gap(input int side);
      int roll;
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         calm_left[side] = $urandom_range(10, 30);
         return 0;
      end
      if (roll < 55) begin
         return 0;
      end
      if (roll < 88) begin
         return $urandom_range(1, 3);
      end
      if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 40);
   endfunction

   // Request driver. Inputs change on the falling edge only; req_hs tells it
   // that the item on the bus was taken at the last rising edge.
   always @(negedge clock) begin : request_driver
      midi_req_t r;
      if (!reset) begin
         if (req_tvalid && !req_hs) begin
            // The block has not taken the request yet, so it stays put.
         end else if (req_wait > 0) begin
            req_wait = req_wait - 1;
            req_tvalid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            r = pending_reqs.pop_front();
            req_item  <= r;
            req_tdata <= {2'b00, r.velo_shift, r.transpose, r.velo_high, r.velo_low,
                          r.pitch_high, r.pitch_low, r.zone, r.second, r.first, r.chan};
            req_tuser <= {r.kind, r.cmd};
            req_tvalid <= 1'b1;
            req_wait = pick_gap(SIDE_REQ);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result sink. A stall may start after any result, and now and then while
   // the block is still working, so that stalls also hit the first result.
   always @(negedge clock) begin : result_sink
      int g;
      if (!reset) begin
         if (rsp_wait > 0) begin
            rsp_wait = rsp_wait - 1;
            rsp_tready <= 1'b0;
         end else begin
            g = (rsp_hs || $urandom_range(0, 15) == 0) ? pick_gap(SIDE_RSP) : 0;
            rsp_tready <= (g == 0);
            rsp_wait = (g > 0) ? g - 1 : 0;
         end
      end
   end

   // Monitor. On each rising edge it checks a result against the oldest
   // expectation first, and only then predicts a request taken at the same
   // edge, so the two never race. It also keeps the cycle count and the limit.
   always @(posedge clock) begin : monitor
      note_out_t want;
      if (reset) begin
         req_hs <= 1'b0;
         rsp_hs <= 1'b0;
      end else begin
         req_hs <= req_tvalid && req_tready;
         rsp_hs <= rsp_tvalid && rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_notes.size() == 0) begin
               flag_mismatch($sformatf("unexpected result kind %0d chan %0d data %0d/%0d",
                  rsp_tuser[1:0], rsp_tdata[3:0], rsp_tdata[10:4], rsp_tdata[17:11]));
            end else begin
               want = expected_notes.pop_front();
               check_field("kind", int'(rsp_tuser[1:0]), int'(want.kind));
               check_field("learned", int'(rsp_tuser[2]), int'(want.learned));
               check_field("channel", int'(rsp_tdata[3:0]), int'(want.chan));
               check_field("first byte", int'(rsp_tdata[10:4]), int'(want.first));
               check_field("second byte", int'(rsp_tdata[17:11]), int'(want.second));
               check_field("tlast", int'(rsp_tlast), int'(want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            route_request(req_item);
            req_accepted <= req_accepted + 1;
         end
      end
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Helpers that build requests. Fields a command does not use are random,
   // so every bit of the request bus but the two top zero bits toggles.
   function automatic midi_req_t any_req();
      midi_req_t r;
      r.cmd        = cmd_type'($urandom_range(0, 3));
      r.kind       = KIND_W'($urandom_range(0, 3));
      r.chan       = CHAN_W'($urandom_range(0, 15));
      r.first      = PITCH_W'($urandom_range(0, 127));
      r.second     = PITCH_W'($urandom_range(0, 127));
      r.zone       = ZIDX_W'($urandom_range(0, 15));
      r.pitch_low  = 8'($urandom_range(0, 255));
      r.pitch_high = 8'($urandom_range(0, 255));
      r.velo_low   = 8'($urandom_range(0, 255));
      r.velo_high  = 8'($urandom_range(0, 255));
      r.transpose  = 8'($urandom_range(0, 255));
      r.velo_shift = 8'($urandom_range(0, 255));
      return r;
   endfunction

   function automatic midi_req_t midi_event(input logic [KIND_W-1:0] kind,
         input int chan, input int first, input int second);
      midi_req_t r;
      r = any_req();
      r.cmd    = CMD_EVENT;
      r.kind   = kind;
      r.chan   = chan[CHAN_W-1:0];
      r.first  = first[PITCH_W-1:0];
      r.second = second[PITCH_W-1:0];
      return r;
   endfunction

   function automatic midi_req_t zone_write(input int zone, input int plo, input int phi,
         input int vlo, input int vhi, input int transpose, input int velo_shift);
      midi_req_t r;
      r = any_req();
      r.cmd        = CMD_WRITE_ZONE;
      r.zone       = zone[ZIDX_W-1:0];
      r.pitch_low  = plo[7:0];
      r.pitch_high = phi[7:0];
      r.velo_low   = vlo[7:0];
      r.velo_high  = vhi[7:0];
      r.transpose  = transpose[7:0];
      r.velo_shift = velo_shift[7:0];
      return r;
   endfunction

   function automatic midi_req_t learn_arm(input cmd_type cmd, input int zone);
      midi_req_t r;
      r = any_req();
      r.cmd  = cmd;
      r.zone = zone[ZIDX_W-1:0];
      return r;
   endfunction

   task automatic queue_req(input midi_req_t r);
      pending_reqs.push_back(r);
      req_queued++;
   endtask

   // Sender pause: nothing more goes out until every request has been taken
   // and every expected result has come back.
   task automatic drain();
      do begin
         @(negedge clock);
      end while (req_accepted != req_queued || expected_notes.size() != 0);
   endtask

   initial begin : stimulus
      int start;
      int roll;
      int idx;
      int lo;
      int p;
      int pool[8];
      logic [PITCH_W-1:0] sounding[$];

      pool = '{0, 36, 48, 60, 64, 72, 100, 127};

      // Reset state of the zone model: zone 0 takes everything, the rest
      // are all zero and so never match a note with nonzero velocity.
      for (int z = 0; z < MNSLR_ZONES; z++) begin
         zn_pitch_low[z]  = '0;
         zn_pitch_high[z] = (z == 0) ? 8'd128 : 8'd0;
         zn_velo_low[z]   = '0;
         zn_velo_high[z]  = (z == 0) ? 8'd128 : 8'd0;
         zn_transpose[z]  = '0;
         zn_velo_shift[z] = '0;
      end
      for (int k = 0; k < KEYS; k++) begin
         held_zones[k] = '0;
      end
      learn_armed      = 1'b0;
      learn_zone       = '0;
      learn_sets_start = 1'b0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part: pass-through of both other kinds, split and layered
      // zones, clamping at both ends of pitch and velocity, releases by
      // note-off and by zero velocity, releases of notes nobody holds, an
      // inverted window, learn of both ends with re-arming, and learn on a
      // note-on of zero velocity.
      queue_req(midi_event(KIND_NOTE_ON, 0, 60, 100));
      queue_req(midi_event(KIND_OTHER, 9, 127, 0));
      queue_req(midi_event(KIND_UNKNOWN, 15, 0, 127));
      queue_req(zone_write(1, 0, 63, 1, 127, 12, 127));
      queue_req(zone_write(15, 48, 128, 64, 128, -127, -127));
      queue_req(midi_event(KIND_NOTE_ON, 3, 0, 127));
      queue_req(midi_event(KIND_NOTE_ON, 0, 60, 100));
      queue_req(midi_event(KIND_NOTE_OFF, 0, 60, 64));
      queue_req(midi_event(KIND_NOTE_ON, 0, 127, 1));
      queue_req(midi_event(KIND_NOTE_ON, 0, 127, 0));
      queue_req(midi_event(KIND_NOTE_OFF, 0, 5, 0));
      queue_req(midi_event(KIND_NOTE_ON, 0, 6, 0));
      queue_req(zone_write(2, 100, 10, 0, 255, -128, 127));
      queue_req(learn_arm(CMD_LEARN_START, 2));
      queue_req(learn_arm(CMD_LEARN_END, 3));
      queue_req(midi_event(KIND_NOTE_OFF, 0, 90, 33));
      queue_req(learn_arm(CMD_LEARN_START, 5));
      queue_req(midi_event(KIND_NOTE_ON, 0, 20, 100));
      queue_req(zone_write(4, 0, 255, 0, 255, 127, -128));
      queue_req(midi_event(KIND_NOTE_ON, 0, 127, 127));
      queue_req(midi_event(KIND_NOTE_OFF, 0, 127, 127));
      queue_req(midi_event(KIND_NOTE_OFF, 0, 0, 0));
      queue_req(learn_arm(CMD_LEARN_END, 7));
      queue_req(midi_event(KIND_NOTE_ON, 0, 0, 0));
      drain();

      // Random part in two halves with a full pause between them. Most of it
      // is played notes and their releases over a zone table that keeps
      // being rewritten; wide zone writes build up layers of many zones.
      for (int half = 0; half < 2; half++) begin
         start = req_queued;
         while (req_queued - start < RANDOM_REQS / 2) begin
            roll = $urandom_range(0, 99);
            if (roll < 40) begin
               p = ($urandom_range(0, 99) < 80) ? pool[$urandom_range(0, 7)]
                                                : $urandom_range(0, 127);
               queue_req(midi_event(KIND_NOTE_ON, $urandom_range(0, 15), p,
                                    $urandom_range(1, 127)));
               sounding.push_back(p[PITCH_W-1:0]);
            end else if (roll < 62) begin
               if (sounding.size() > 0 && $urandom_range(0, 9) != 0) begin
                  idx = $urandom_range(0, sounding.size() - 1);
                  p = int'(sounding[idx]);
                  sounding.delete(idx);
               end else begin
                  p = $urandom_range(0, 127);
               end
               if ($urandom_range(0, 99) < 30) begin
                  queue_req(midi_event(KIND_NOTE_ON, $urandom_range(0, 15), p, 0));
               end else begin
                  queue_req(midi_event(KIND_NOTE_OFF, $urandom_range(0, 15), p,
                                       $urandom_range(0, 127)));
               end
            end else if (roll < 74) begin
               idx = $urandom_range(0, 99);
               if (idx < 60) begin
                  lo = $urandom_range(0, 100);
                  queue_req(zone_write($urandom_range(0, 15), lo, $urandom_range(lo, 128),
                     $urandom_range(0, 40), $urandom_range(80, 128),
                     $urandom_range(0, 48) - 24, $urandom_range(0, 48) - 24));
               end else if (idx < 85) begin
                  queue_req(zone_write($urandom_range(0, 15), 0, 128, 0, 128,
                     $urandom_range(0, 254) - 127, $urandom_range(0, 254) - 127));
               end else begin
                  queue_req(zone_write($urandom_range(0, 15), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255)));
               end
            end else if (roll < 80) begin
               // Learn sequence, sometimes re-armed before the capturing note.
               queue_req(learn_arm($urandom_range(0, 1) ? CMD_LEARN_START : CMD_LEARN_END,
                                   $urandom_range(0, 15)));
               if ($urandom_range(0, 3) == 0) begin
                  queue_req(learn_arm($urandom_range(0, 1) ? CMD_LEARN_START : CMD_LEARN_END,
                                      $urandom_range(0, 15)));
               end
               queue_req(midi_event($urandom_range(0, 1) ? KIND_NOTE_ON : KIND_NOTE_OFF,
                  $urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 127)));
            end else if (roll < 90) begin
               queue_req(midi_event($urandom_range(0, 1) ? KIND_OTHER : KIND_UNKNOWN,
                  $urandom_range(0, 15), $urandom_range(0, 127), $urandom_range(0, 127)));
            end else begin
               queue_req(any_req());
            end
         end
         drain();
      end

      // Give the block time to show any stray result before the verdict.
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_notes.size() != 0) begin
         flag_mismatch($sformatf("%0d expected results never arrived",
                                 expected_notes.size()));
      end
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
